// File: rtl/pcrl_pkg.sv
// Shared types and constants for the per-client rate limiter.
// No dependencies; imported by pcrl_cell and per_client_rate_limiter.
package pcrl_pkg;

  localparam int CFG_IDX_BITS  = 1;
  localparam int CFG_DATA_BITS = 32;
  localparam int COUNT_BITS    = 16;
  localparam int TIME_BITS     = 32;
  localparam int SLOT_BITS     = 4;

  localparam logic [COUNT_BITS-1:0] MAX_REQ_RESET = 16'd60;
  localparam logic [TIME_BITS-1:0]  WINDOW_RESET  = 32'd60;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_MAX_REQ = 1'b0,
    CFG_WINDOW  = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESP
  } state_e;

  // Lookup token passed down the cell chain.
  typedef struct packed {
    logic                 valid;
    logic                 matched;
    logic                 allowed;
    logic [TIME_BITS-1:0] vstart;
  } probe_t;

endpackage

// File: rtl/per_client_rate_limiter.sv
// Per-client fixed-window rate limiter: a chain of ENTRIES table cells that a
// lookup token walks one cell per cycle. Depends on pcrl_pkg and pcrl_cell.
// out_valid_o rises once the token has left the last cell and the result is registered.
// The spacing of transactions is set by the token walk through the cell chain, the
// result register and any output stall; one transaction in flight.
// Reset: all entries invalid, max_requests = 60, window_length = 60.
module per_client_rate_limiter #(
  parameter int ENTRIES  = 16,
  parameter int KEY_BITS = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [pcrl_pkg::CFG_IDX_BITS-1:0]    cfg_idx_i,
  input  logic [pcrl_pkg::CFG_DATA_BITS-1:0]   cfg_wdata_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [31:0]                          client_key_i,
  input  logic [31:0]                          now_time_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic                                 allowed_o,
  output logic                                 matched_o,
  output logic [pcrl_pkg::SLOT_BITS-1:0]       slot_o
);
  import pcrl_pkg::*;

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  state_e state_q, state_d;

  logic [COUNT_BITS-1:0] max_requests_q;
  logic [TIME_BITS-1:0]  window_length_q;

  logic [KEY_BITS-1:0]   key_q;
  logic [TIME_BITS-1:0]  now_q;
  logic [KEY_BITS+31:0]  key_ext;

  probe_t                probe [ENTRIES+1];
  logic [IDX_W-1:0]      idx   [ENTRIES+1];
  logic [ENTRIES:0]      chain_valid;

  probe_t                probe0_q;
  logic                  in_acc;
  logic                  done;
  logic                  wr_en;

  logic                  allowed_q;
  logic                  matched_q;
  logic [SLOT_BITS-1:0]  slot_q;
  logic [IDX_W+3:0]      slot_ext;

  assign key_ext  = {{KEY_BITS{1'b0}}, client_key_i};
  assign in_acc   = in_valid_i && !in_stall_o;
  assign done     = probe[ENTRIES].valid;
  assign wr_en    = done && !probe[ENTRIES].matched;
  assign slot_ext = {4'b0, idx[ENTRIES]};

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_requests_q  <= MAX_REQ_RESET;
      window_length_q <= WINDOW_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MAX_REQ: max_requests_q  <= cfg_wdata_i[COUNT_BITS-1:0];
        CFG_WINDOW:  window_length_q <= cfg_wdata_i[TIME_BITS-1:0];
        default: ;
      endcase
    end
  end

  // state machine
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_SCAN;
      ST_SCAN: if (done) state_d = ST_RESP;
      ST_RESP: if (!out_stall_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    case (state_q)
      ST_IDLE: begin
        in_stall_o  = 1'b0;
        out_valid_o = 1'b0;
      end
      ST_SCAN: begin
        in_stall_o  = 1'b1;
        out_valid_o = 1'b0;
      end
      ST_RESP: begin
        in_stall_o  = 1'b1;
        out_valid_o = 1'b1;
      end
      default: begin
        in_stall_o  = 1'b1;
        out_valid_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      probe0_q <= '0;
    end else begin
      state_q        <= state_d;
      probe0_q.valid <= in_acc;
      if (in_acc) begin
        probe0_q.matched <= 1'b0;
        probe0_q.allowed <= 1'b0;
        probe0_q.vstart  <= '1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      key_q <= key_ext[KEY_BITS-1:0];
      now_q <= now_time_i;
    end
    if (done) begin
      allowed_q <= probe[ENTRIES].matched ? probe[ENTRIES].allowed : 1'b1;
      matched_q <= probe[ENTRIES].matched;
      slot_q    <= slot_ext[SLOT_BITS-1:0];
    end
  end

  assign probe[0] = probe0_q;
  assign idx[0]   = '0;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    pcrl_cell #(
      .KEY_BITS (KEY_BITS),
      .IDX_W    (IDX_W),
      .IDX      (i)
    ) u_cell (
      .clk_i           (clk_i),
      .rst_ni          (rst_ni),
      .max_requests_i  (max_requests_q),
      .window_length_i (window_length_q),
      .key_i           (key_q),
      .now_i           (now_q),
      .probe_i         (probe[i]),
      .idx_i           (idx[i]),
      .probe_o         (probe[i+1]),
      .idx_o           (idx[i+1]),
      .wr_en_i         (wr_en),
      .wr_idx_i        (idx[ENTRIES])
    );
  end

  for (genvar i = 0; i <= ENTRIES; i++) begin : g_cv
    assign chain_valid[i] = probe[i].valid;
  end

  assign allowed_o = allowed_q;
  assign matched_o = matched_q;
  assign slot_o    = slot_q;

  a_one_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(chain_valid))
    else $error("more than one lookup token in the chain");

  a_accept_launch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> probe0_q.valid)
    else $error("accepted transaction did not launch a token");

  a_done_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |=> out_valid_o)
    else $error("finished lookup did not produce a result");

  a_idle_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ($countones(chain_valid) == 0))
    else $error("token in chain while result pending");

endmodule

// File: rtl/pcrl_cell.sv
// One table entry of the rate limiter: holds key, count and window start,
// checks the passing lookup token and hands it on. Depends on pcrl_pkg.
module pcrl_cell #(
  parameter int KEY_BITS = 32,
  parameter int IDX_W    = 4,
  parameter int IDX      = 0
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [pcrl_pkg::COUNT_BITS-1:0] max_requests_i,
  input  logic [pcrl_pkg::TIME_BITS-1:0]  window_length_i,
  input  logic [KEY_BITS-1:0]             key_i,
  input  logic [pcrl_pkg::TIME_BITS-1:0]  now_i,
  input  pcrl_pkg::probe_t                probe_i,
  input  logic [IDX_W-1:0]                idx_i,
  output pcrl_pkg::probe_t                probe_o,
  output logic [IDX_W-1:0]                idx_o,
  input  logic                            wr_en_i,
  input  logic [IDX_W-1:0]                wr_idx_i
);
  import pcrl_pkg::*;

  logic                  valid_q;
  logic [KEY_BITS-1:0]   key_q;
  logic [COUNT_BITS-1:0] count_q;
  logic [TIME_BITS-1:0]  start_q;

  probe_t                probe_d, probe_q;
  logic [IDX_W-1:0]      idx_d, idx_q;

  logic                  hit;
  logic                  expired;
  logic                  limited;
  logic                  wr_sel;
  logic [TIME_BITS-1:0]  age;
  logic [TIME_BITS-1:0]  eff_start;

  always_comb begin
    hit       = probe_i.valid && !probe_i.matched && valid_q && (key_q == key_i);
    age       = now_i - start_q;
    expired   = age >= window_length_i;
    limited   = count_q >= max_requests_i;
    eff_start = valid_q ? start_q : '0;
    wr_sel    = wr_en_i && (wr_idx_i == IDX_W'(IDX));

    probe_d = probe_i;
    idx_d   = idx_i;
    if (hit) begin
      probe_d.matched = 1'b1;
      probe_d.allowed = expired || !limited;
      idx_d           = IDX_W'(IDX);
    end else if (probe_i.valid && !probe_i.matched && (eff_start < probe_i.vstart)) begin
      probe_d.vstart = eff_start;
      idx_d          = IDX_W'(IDX);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      probe_q <= '0;
    end else begin
      probe_q <= probe_d;
      if (wr_sel) begin
        valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    if (wr_sel) begin
      key_q   <= key_i;
      count_q <= COUNT_BITS'(1);
      start_q <= now_i;
    end else if (hit) begin
      if (expired) begin
        count_q <= COUNT_BITS'(1);
        start_q <= now_i;
      end else if (!limited) begin
        count_q <= count_q + COUNT_BITS'(1);
      end
    end
  end

  assign probe_o = probe_q;
  assign idx_o   = idx_q;

endmodule

// File: sim/tb_per_client_rate_limiter.sv
// Self-checking testbench for per_client_rate_limiter: directed and random requests
// against an in-bench model of the client table, with random input gaps and output stalls.
// Depends on pcrl_pkg and the per_client_rate_limiter RTL.
module tb_per_client_rate_limiter;
  import pcrl_pkg::*;

  localparam int SLOTS      = 16;
  localparam int DRAIN      = 30;
  localparam int CYCLE_MAX  = 1_000_000;
  localparam int REPORT_MAX = 10;

  typedef struct packed {
    logic                 allowed;
    logic                 matched;
    logic [SLOT_BITS-1:0] slot;
  } verdict_t;

  class verdict_board;
    logic [COUNT_BITS-1:0] limit;
    logic [TIME_BITS-1:0]  window;
    bit                    used[SLOTS];
    logic [31:0]           keys[SLOTS];
    logic [COUNT_BITS-1:0] counts[SLOTS];
    logic [TIME_BITS-1:0]  starts[SLOTS];
    verdict_t              verdict_q[$];
    int unsigned           mismatches;

    function new();
      limit      = MAX_REQ_RESET;
      window     = WINDOW_RESET;
      mismatches = 0;
      foreach (used[i]) begin
        used[i]   = 1'b0;
        keys[i]   = '0;
        counts[i] = '0;
        starts[i] = '0;
      end
    endfunction

    function void set_reg(cfg_reg_e idx, logic [CFG_DATA_BITS-1:0] data);
      if (idx == CFG_MAX_REQ) begin
        limit = data[COUNT_BITS-1:0];
      end else begin
        window = data[TIME_BITS-1:0];
      end
    endfunction

    function int pending();
      return verdict_q.size();
    endfunction

    // Table lookup and update for one accepted transaction.
    function void log_request(logic [31:0] key, logic [TIME_BITS-1:0] stamp);
      verdict_t             v;
      bit                   hit;
      int                   victim;
      logic [TIME_BITS-1:0] oldest;
      logic [TIME_BITS-1:0] s;
      logic [TIME_BITS-1:0] age;
      hit = 1'b0;
      v   = '0;
      for (int i = 0; i < SLOTS; i++) begin
        if (!hit && used[i] && keys[i] == key) begin
          hit = 1'b1;
          age = stamp - starts[i];
          if (age >= window) begin
            counts[i] = COUNT_BITS'(1);
            starts[i] = stamp;
            v.allowed = 1'b1;
          end else if (counts[i] >= limit) begin
            v.allowed = 1'b0;
          end else begin
            counts[i] = counts[i] + COUNT_BITS'(1);
            v.allowed = 1'b1;
          end
          v.matched = 1'b1;
          v.slot    = i[SLOT_BITS-1:0];
        end
      end
      if (!hit) begin
        victim = 0;
        oldest = used[0] ? starts[0] : '0;
        for (int i = 1; i < SLOTS; i++) begin
          s = used[i] ? starts[i] : '0;
          if (s < oldest) begin
            oldest = s;
            victim = i;
          end
        end
        used[victim]   = 1'b1;
        keys[victim]   = key;
        counts[victim] = COUNT_BITS'(1);
        starts[victim] = stamp;
        v.allowed = 1'b1;
        v.matched = 1'b0;
        v.slot    = victim[SLOT_BITS-1:0];
      end
      verdict_q.push_back(v);
    endfunction

    function void flag(string what, int exp_v, int act_v);
      mismatches++;
      if (mismatches <= REPORT_MAX) begin
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, exp_v, act_v);
      end
    endfunction

    function void check_verdict(logic allowed, logic matched, logic [SLOT_BITS-1:0] slot);
      verdict_t v;
      if (verdict_q.size() == 0) begin
        flag("unexpected transaction, slot", -1, int'(slot));
      end else begin
        v = verdict_q.pop_front();
        if (allowed !== v.allowed) flag("allowed", int'(v.allowed), int'(allowed));
        if (matched !== v.matched) flag("matched", int'(v.matched), int'(matched));
        if (slot !== v.slot) flag("slot", int'(v.slot), int'(slot));
      end
    endfunction
  endclass

  logic                     clk_i;
  logic                     rst_ni;
  logic                     cfg_we_i;
  logic [CFG_IDX_BITS-1:0]  cfg_idx_i;
  logic [CFG_DATA_BITS-1:0] cfg_wdata_i;
  logic                     in_valid_i;
  logic                     in_stall_o;
  logic [31:0]              client_key_i;
  logic [31:0]              now_time_i;
  logic                     out_valid_o;
  logic                     out_stall_i;
  logic                     allowed_o;
  logic                     matched_o;
  logic [SLOT_BITS-1:0]     slot_o;

  verdict_board sb = new();
  bit           steady;
  logic [31:0]  clock_now;
  int unsigned  cycles;

  per_client_rate_limiter uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .client_key_i(client_key_i),
    .now_time_i  (now_time_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .allowed_o   (allowed_o),
    .matched_o   (matched_o),
    .slot_o      (slot_o)
  );

  initial clk_i = 1'b0;
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_MAX) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_verdict(allowed_o, matched_o, slot_o);
    end
  end

  // Mostly short pauses, a few long ones.
  function automatic int pick_pause();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  initial begin
    out_stall_i = 1'b0;
    forever begin
      repeat ($urandom_range(1, 6)) @(negedge clk_i) out_stall_i <= 1'b0;
      if (!steady) begin
        repeat (pick_pause()) @(negedge clk_i) out_stall_i <= 1'b1;
      end
    end
  end

  task automatic send_request(logic [31:0] key, logic [31:0] stamp);
    int pause;
    pause = steady ? 0 : pick_pause();
    repeat (pause) @(negedge clk_i) in_valid_i <= 1'b0;
    @(negedge clk_i);
    in_valid_i   <= 1'b1;
    client_key_i <= key;
    now_time_i   <= stamp;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.log_request(key, stamp);
  endtask

  task automatic settle();
    @(negedge clk_i) in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CFG_DATA_BITS-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    sb.set_reg(idx, data);
    @(negedge clk_i) cfg_we_i <= 1'b0;
  endtask

  // Recurring clients with slowly advancing time, plus stray keys and time jumps.
  task automatic run_traffic(int n, int pool_n, int step);
    logic [31:0] pool[24];
    int          r;
    foreach (pool[i]) pool[i] = $urandom;
    pool[0] = '0;
    pool[1] = '1;
    for (int j = 0; j < n; j++) begin
      r = $urandom_range(0, 99);
      if (r < 85) begin
        clock_now += $urandom_range(0, step);
        send_request(pool[$urandom_range(0, pool_n - 1)], clock_now);
      end else if (r < 92) begin
        send_request($urandom, clock_now);
      end else if (r < 96) begin
        clock_now += $urandom;
        send_request(pool[$urandom_range(0, pool_n - 1)], clock_now);
      end else begin
        send_request($urandom, $urandom);
      end
    end
  endtask

  task automatic phase(logic [31:0] lim, logic [31:0] win, int pool_n, int step);
    write_reg(CFG_MAX_REQ, lim);
    write_reg(CFG_WINDOW, win);
    steady = ($urandom_range(0, 3) == 0);
    run_traffic(150, pool_n, step);
    settle();
  endtask

  initial begin
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = CFG_MAX_REQ;
    cfg_wdata_i  = '0;
    in_valid_i   = 1'b0;
    client_key_i = '0;
    now_time_i   = '0;
    steady       = 1'b0;
    clock_now    = '0;
    cycles       = 0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    // Reset settings: empty table, eviction order, window edge and time wrap.
    send_request(32'h0000_0000, 32'h0000_0000);
    send_request(32'h0000_0000, 32'h0000_0000);
    send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    for (int k = 1; k <= SLOTS; k++) begin
      send_request(32'h1000_0000 + k, 32'd100 + k);
    end
    send_request(32'h1000_0002, 32'd161);
    send_request(32'h1000_0002, 32'd162);
    send_request(32'h1000_0003, 32'd2);
    settle();

    steady = 1'b0;
    run_traffic(150, 12, 1);
    settle();
    phase(32'd2, 32'd8, 10, 2);
    phase(32'd0, 32'd16, 10, 1);
    phase(32'd4, 32'd0, 20, 3);
    phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 24, 1000);
    clock_now = 32'hFFFF_FFC0;
    phase(32'd1, 32'd1, 12, 1);
    phase(32'd5, 32'd30, 16, 4);
    phase($urandom_range(1, 8), $urandom_range(1, 64), 14, 3);
    phase($urandom, $urandom_range(1, 40), 10, 2);

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/pcrl_pkg.sv
rtl/pcrl_cell.sv
rtl/per_client_rate_limiter.sv
sim/tb_per_client_rate_limiter.sv
